FILE: rtl/core/falru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falru_pkg
// Shared widths, reset values and cell control types for the fully
// associative LRU tag store.
// ----------------------------------------------------------------------------
package falru_pkg;

	localparam int ADDR_W        = 64;
	localparam int OFFS_W        = 5;
	localparam int LINE_W        = 4;
	localparam int CNT_W         = 32;
	localparam int LINES_DEFAULT = 16;

	localparam logic [OFFS_W-1:0] OFFS_RESET = 5'd6;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// what a cell reports during lookup
	typedef struct packed {
		logic valid;
		logic match;
		logic first_free;
		logic lru;
	} cell_stat_t;

	// update command broadcast to every cell
	typedef struct packed {
		logic commit;
		logic sel;
		logic miss;
	} cell_cmd_t;

endpackage

FILE: rtl/core/falru_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falru_addr_if / falru_rsp_if
// Valid/ready channels for lookup addresses and lookup results.
// ----------------------------------------------------------------------------
interface falru_addr_if;
	logic            valid;
	logic            ready;
	falru_pkg::addr_t address;

	modport source (output valid, output address, input ready);
	modport sink   (input valid, input address, output ready);
endinterface

interface falru_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [falru_pkg::LINE_W-1:0]  line_used;
	logic                          evicted;
	falru_pkg::cnt_t               hit_total;
	falru_pkg::cnt_t               miss_total;

	modport source (output valid, output hit, output line_used, output evicted,
		output hit_total, output miss_total, input ready);
	modport sink   (input valid, input hit, input line_used, input evicted,
		input hit_total, input miss_total, output ready);
endinterface

FILE: rtl/core/falru_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falru_cell
// One line of the tag store: tag, valid bit and recency rank, with the local
// compare and the rank aging rule.
// ----------------------------------------------------------------------------
module falru_cell #(
	parameter int LINES = falru_pkg::LINES_DEFAULT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  falru_pkg::addr_t        tag,
	input  logic                    prev_valid,
	input  falru_pkg::cell_cmd_t    cmd,
	input  logic [((LINES > 1) ? $clog2(LINES) : 1)-1:0] sel_rank,
	output falru_pkg::cell_stat_t   stat,
	output logic [((LINES > 1) ? $clog2(LINES) : 1)-1:0] rank
);

	localparam int RW = (LINES > 1) ? $clog2(LINES) : 1;
	localparam logic [RW-1:0] RANK_MAX = RW'(LINES - 1);

	falru_pkg::addr_t tag_q;
	logic             valid_q;
	logic [RW-1:0]    rank_q;

	assign rank = rank_q;

	// lines fill in index order, so the first free line is the one whose
	// lower neighbor is valid
	assign stat.valid      = valid_q;
	assign stat.match      = valid_q && (tag_q == tag);
	assign stat.first_free = !valid_q && prev_valid;
	assign stat.lru        = valid_q && (rank_q == RANK_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (cmd.commit) begin
			if (cmd.sel) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
			end else if (valid_q && (cmd.miss || rank_q < sel_rank)) begin
				rank_q <= rank_q + RW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && cmd.sel && cmd.miss) begin
			tag_q <= tag;
		end
	end

endmodule

FILE: rtl/core/fully_assoc_lru_tag_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fully_assoc_lru_tag_store
// Fully associative tag store with LRU replacement and saturating hit and
// miss counters.
// ----------------------------------------------------------------------------
// Each address transfer passes through a lookup phase, in which every
// line compares its tag and reports free/LRU status, and a commit phase in
// which the chosen line and the recency ranks of all lines update and the
// result is loaded into the output register. The next address is taken in
// the commit phase, so lookups do not overlap; a stalled result holds the
// commit until the output register frees. Valid bits and ranks clear at
// reset at once; there is no clearing pass. The tag is the address shifted
// right by offset_q, which the user must write through cfg_we/cfg_wdata
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module fully_assoc_lru_tag_store #(
	parameter int LINES = falru_pkg::LINES_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [falru_pkg::OFFS_W-1:0]   cfg_wdata,
	falru_addr_if.sink                     req,
	falru_rsp_if.source                    rsp
);

	localparam int RW = (LINES > 1) ? $clog2(LINES) : 1;

	logic [falru_pkg::OFFS_W-1:0] offset_q;
	logic                         p1_q;
	logic                         p2_q;
	logic                         p2_fire;
	falru_pkg::addr_t             tag_s1;

	logic                         hit_s2;
	logic                         evict_s2;
	logic [RW-1:0]                line_s2;
	logic [RW-1:0]                srank_s2;
	logic [LINES-1:0]             sel_s2;

	falru_pkg::cnt_t              hit_count_q;
	falru_pkg::cnt_t              miss_count_q;
	falru_pkg::cnt_t              hit_next;
	falru_pkg::cnt_t              miss_next;

	logic                         rsp_valid_q;
	logic                         rsp_hit_q;
	logic [falru_pkg::LINE_W-1:0] rsp_line_q;
	logic                         rsp_evict_q;
	falru_pkg::cnt_t              rsp_hit_total_q;
	falru_pkg::cnt_t              rsp_miss_total_q;

	falru_pkg::cell_stat_t        stat [LINES];
	falru_pkg::cell_cmd_t         cmd  [LINES];
	logic [RW-1:0]                rank [LINES];
	logic [LINES-1:0]             valid_vec;
	logic [LINES-1:0]             sel_c;
	logic                         hit_c;
	logic                         full_c;
	logic [RW-1:0]                line_c;
	logic [RW-1:0]                srank_c;

	assign p2_fire   = p2_q && (!rsp_valid_q || rsp.ready);
	assign req.ready = !p1_q && (!p2_q || p2_fire);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= falru_pkg::OFFS_RESET;
		end else if (cfg_we) begin
			offset_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			tag_s1 <= req.address >> offset_q;
		end
	end

	// ---------------- cell row ----------------
	genvar gi;
	generate
		for (gi = 0; gi < LINES; gi++) begin : g_cell
			logic prev_v;
			if (gi == 0) begin : g_head
				assign prev_v = 1'b1;
			end else begin : g_link
				assign prev_v = stat[gi-1].valid;
			end

			assign cmd[gi].commit = p2_fire;
			assign cmd[gi].sel    = sel_s2[gi];
			assign cmd[gi].miss   = !hit_s2;
			assign valid_vec[gi]  = stat[gi].valid;

			falru_cell #(
				.LINES (LINES)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.tag        (tag_s1),
				.prev_valid (prev_v),
				.cmd        (cmd[gi]),
				.sel_rank   (srank_s2),
				.stat       (stat[gi]),
				.rank       (rank[gi])
			);
		end
	endgenerate

	// ---------------- lookup ----------------
	// tags are unique among valid lines and ranks are distinct, so at most
	// one cell matches and exactly one holds the LRU rank when the row is full
	always_comb begin
		hit_c   = 1'b0;
		line_c  = '0;
		srank_c = '0;
		for (int i = 0; i < LINES; i++) begin
			hit_c = hit_c | stat[i].match;
		end
		full_c = valid_vec[LINES-1];
		for (int i = 0; i < LINES; i++) begin
			if (hit_c) begin
				sel_c[i] = stat[i].match;
			end else if (full_c) begin
				sel_c[i] = stat[i].lru;
			end else begin
				sel_c[i] = stat[i].first_free;
			end
			line_c  = line_c  | (sel_c[i] ? RW'(i) : '0);
			srank_c = srank_c | (sel_c[i] ? rank[i] : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_q <= 1'b0;
			p2_q <= 1'b0;
		end else begin
			p1_q <= req.valid && req.ready;
			if (p1_q) begin
				p2_q <= 1'b1;
			end else if (p2_fire) begin
				p2_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (p1_q) begin
			hit_s2   <= hit_c;
			evict_s2 <= !hit_c && full_c;
			line_s2  <= line_c;
			srank_s2 <= srank_c;
			sel_s2   <= sel_c;
		end
	end

	// ---------------- commit ----------------
	assign hit_next  = (hit_s2 && hit_count_q != '1) ? hit_count_q + 1'b1 : hit_count_q;
	assign miss_next = (!hit_s2 && miss_count_q != '1) ? miss_count_q + 1'b1 : miss_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_count_q  <= '0;
			miss_count_q <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (p2_fire) begin
				hit_count_q  <= hit_next;
				miss_count_q <= miss_next;
				rsp_valid_q  <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (p2_fire) begin
			rsp_hit_q        <= hit_s2;
			rsp_line_q       <= falru_pkg::LINE_W'(line_s2);
			rsp_evict_q      <= evict_s2;
			rsp_hit_total_q  <= hit_next;
			rsp_miss_total_q <= miss_next;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.hit        = rsp_hit_q;
	assign rsp.line_used  = rsp_line_q;
	assign rsp.evicted    = rsp_evict_q;
	assign rsp.hit_total  = rsp_hit_total_q;
	assign rsp.miss_total = rsp_miss_total_q;

	// ---------------- assertions ----------------
	a_phase_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(p1_q && p2_q))
		else $error("lookup and commit phases overlap");

	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + 1'b1)) == '0)
		else $error("valid lines are not a contiguous prefix");

	a_one_sel: assert property (@(posedge clk) disable iff (!arst_n)
		p1_q |-> $onehot(sel_c))
		else $error("lookup did not select exactly one line");

	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(p2_q && evict_s2) |-> (&valid_vec))
		else $error("eviction while a free line exists");

endmodule

FILE: test/falru_lookup_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falru_lookup_checker
// Passive checker for the LRU tag store. It watches the address and result
// channels and the offset register writes, and keeps its own copy of the
// tags, valid bits, recency ranks and counters. It queues the expected
// result for each address transfer and compares every result transfer
// against the oldest entry.
// ----------------------------------------------------------------------------
module falru_lookup_checker #(
	parameter int LINES = falru_pkg::LINES_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [falru_pkg::OFFS_W-1:0] cfg_wdata,
	falru_addr_if                        req,
	falru_rsp_if                         rsp,
	output int                           fail_count,
	output int                           outstanding
);
	import falru_pkg::*;

	typedef struct packed {
		logic              hit;
		logic [LINE_W-1:0] line_used;
		logic              evicted;
		cnt_t              hit_total;
		cnt_t              miss_total;
	} lookup_result_t;

	addr_t             line_tag_q [LINES];
	bit                line_live  [LINES];
	logic [LINE_W-1:0] line_age   [LINES];
	cnt_t              hit_cnt;
	cnt_t              miss_cnt;
	logic [OFFS_W-1:0] offset_bits;

	lookup_result_t expected_lookups[$];
	lookup_result_t got;
	lookup_result_t want;
	int             mismatches;

	task automatic predict_lookup(input addr_t address, output lookup_result_t r);
		addr_t             tag;
		int                sel;
		bit                found;
		logic [LINE_W-1:0] best;
		logic [LINE_W:0]   limit;
		tag = address >> offset_bits;
		sel = 0;
		found = 0;
		r = '0;
		// lowest matching index wins the parallel compare
		for (int i = 0; i < LINES; i++) begin
			if (!found && line_live[i] && line_tag_q[i] == tag) begin
				sel = i;
				found = 1;
			end
		end
		if (found) begin
			r.hit = 1'b1;
			if (hit_cnt != '1)
				hit_cnt = hit_cnt + 1;
			limit = {1'b0, line_age[sel]};
		end else begin
			if (miss_cnt != '1)
				miss_cnt = miss_cnt + 1;
			for (int i = 0; i < LINES; i++) begin
				if (!found && !line_live[i]) begin
					sel = i;
					found = 1;
				end
			end
			if (!found) begin
				// all lines valid: replace the oldest one
				best = '0;
				for (int i = 0; i < LINES; i++) begin
					if (line_age[i] > best) begin
						best = line_age[i];
						sel = i;
					end
				end
				r.evicted = 1'b1;
			end
			line_live[sel] = 1'b1;
			line_tag_q[sel] = tag;
			limit = {1'b1, {LINE_W{1'b0}}};
		end
		for (int i = 0; i < LINES; i++) begin
			if (i != sel && line_live[i] && {1'b0, line_age[i]} < limit)
				line_age[i] = line_age[i] + 1'b1;
		end
		line_age[sel] = '0;
		r.line_used = LINE_W'(sel);
		r.hit_total = hit_cnt;
		r.miss_total = miss_cnt;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LINES; i++) begin
				line_tag_q[i] = '0;
				line_live[i] = 1'b0;
				line_age[i] = '0;
			end
			hit_cnt = '0;
			miss_cnt = '0;
			offset_bits = OFFS_RESET;
			expected_lookups.delete();
			mismatches = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.hit = rsp.hit;
				got.line_used = rsp.line_used;
				got.evicted = rsp.evicted;
				got.hit_total = rsp.hit_total;
				got.miss_total = rsp.miss_total;
				if (expected_lookups.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transfer: %s",
							$sformatf("hit=%0b line=%0d evict=%0b hits=%0d misses=%0d",
							got.hit, got.line_used, got.evicted, got.hit_total,
							got.miss_total));
				end else begin
					want = expected_lookups.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result mismatch: exp %s",
								$sformatf("hit=%0b line=%0d evict=%0b hits=%0d misses=%0d",
								want.hit, want.line_used, want.evicted, want.hit_total,
								want.miss_total));
							$display("                 got %s",
								$sformatf("hit=%0b line=%0d evict=%0b hits=%0d misses=%0d",
								got.hit, got.line_used, got.evicted, got.hit_total,
								got.miss_total));
						end
					end
				end
			end
			if (req.valid && req.ready) begin
				predict_lookup(req.address, want);
				expected_lookups.push_back(want);
			end
			if (cfg_we)
				offset_bits = cfg_wdata;
			fail_count <= mismatches;
			outstanding <= expected_lookups.size();
		end
	end

endmodule

FILE: test/fully_assoc_lru_tag_store_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fully_assoc_lru_tag_store_tb
// Stimulus and verdict for the LRU tag store. A directed run fills every
// line, evicts and hits; random phases then sweep the offset register over
// its extremes with address pools sized for hits, fills and LRU thrashing,
// under three sender/receiver idling mixes. Checking is in the checker.
// ----------------------------------------------------------------------------
module fully_assoc_lru_tag_store_tb;
	import falru_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 250;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we;
	logic [OFFS_W-1:0] cfg_wdata;

	falru_addr_if req_ch();
	falru_rsp_if  rsp_ch();

	int fail_count;
	int outstanding;
	int cycle_count = 0;
	int send_idle_pct;
	int recv_idle_pct;

	logic [OFFS_W-1:0] cur_offset;
	addr_t             addr_pool[32];
	int                pool_size;

	fully_assoc_lru_tag_store dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	falru_lookup_checker checker_inst (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL fully_assoc_lru_tag_store");
			$finish;
		end
	end

	always @(posedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

	function automatic addr_t rand_word();
		return {$urandom, $urandom};
	endfunction

	// mostly addresses from the pool with random bytes inside the block
	function automatic addr_t pick_address();
		addr_t mask;
		if ($urandom_range(99) < 12)
			return rand_word();
		mask = (64'd1 << cur_offset) - 64'd1;
		return (addr_pool[$urandom_range(pool_size - 1)] & ~mask) | (rand_word() & mask);
	endfunction

	task automatic send_address(input addr_t a);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.address <= a;
		do
			@(posedge clk);
		while (!(req_ch.valid && req_ch.ready));
	endtask

	// hold off the sender until every queued result has come back
	task automatic drain();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_offset(input logic [OFFS_W-1:0] v);
		drain();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_offset = v;
	endtask

	initial begin
		logic [OFFS_W-1:0] settings[6];
		int                pool_sizes[4];
		req_ch.valid = 1'b0;
		req_ch.address = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		send_idle_pct = 24;
		recv_idle_pct = 49;
		cur_offset = OFFS_RESET;
		settings = '{5'd0, 5'd16, 5'd31, 5'd17, 5'd6, 5'd0};
		settings[5] = OFFS_W'($urandom_range(31));
		pool_sizes = '{4, 16, 17, 28};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: same-block hits, extreme addresses, fill all lines, evict
		send_address(64'd0);
		send_address(64'd63);
		send_address(64'hFFFF_FFFF_FFFF_FFFF);
		send_address(64'hFFFF_FFFF_FFFF_FFC0);
		for (int i = 1; i <= 14; i++)
			send_address(addr_t'(i) << 6);
		send_address(addr_t'(15) << 6);
		send_address(addr_t'(1) << 6);
		send_address(64'd0);
		send_address(64'h8000_0000_0000_0000);
		send_address(64'hFFFF_FFFF_FFFF_FFFF);
		drain();

		for (int k = 0; k < 6; k++) begin
			case (k / 2)
				0: begin
					send_idle_pct = 24;
					recv_idle_pct = 49;
				end
				1: begin
					send_idle_pct = 49;
					recv_idle_pct = 24;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			write_offset(settings[k]);
			pool_size = pool_sizes[$urandom_range(3)];
			for (int p = 0; p < pool_size; p++)
				addr_pool[p] = rand_word();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2)
					drain();
				send_address(pick_address());
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("PASS fully_assoc_lru_tag_store");
		else
			$display("FAIL fully_assoc_lru_tag_store");
		$finish;
	end

endmodule

FILE: fully_assoc_lru_tag_store.f
rtl/core/falru_pkg.sv
rtl/core/falru_if.sv
rtl/core/falru_cell.sv
rtl/core/fully_assoc_lru_tag_store.sv
test/falru_lookup_checker.sv
test/fully_assoc_lru_tag_store_tb.sv
